// ===== rtl/bhtda_pkg.sv =====
// Shared types and constants for the bucketed hash table with depth/age replacement.
// No dependencies; every other file of the block imports this package.
package bhtda_pkg;

    // Command codes
    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // Bound kinds
    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_EXACT = 2'd3;

    // Configuration register indexes and widths
    localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
    localparam logic [1:0] CFG_CUR_GEN      = 2'd1;
    localparam logic [1:0] CFG_MATE_THRESH  = 2'd2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [16:0] BUCKET_COUNT_RST = 17'd65536;
    localparam logic [4:0]  CUR_GEN_RST      = 5'd0;
    localparam logic [14:0] MATE_THRESH_RST  = 15'd31000;

    localparam int ENTRY_W = 80;

    typedef struct packed {
        logic               cmd;
        logic [63:0]        key;
        logic [7:0]         ply;
        logic [7:0]         search_depth;
        logic signed [15:0] eval_score;
        logic signed [15:0] static_eval;
        logic [15:0]        best_move;
        logic               pv_flag;
        logic [1:0]         bound_kind;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] found_score;
        logic signed [15:0] found_eval;
        logic [15:0]        found_move;
        logic [7:0]         found_depth;
        logic [1:0]         found_bound;
        logic               found_pv;
    } rsp_t;

    // One stored entry, 80 bits
    typedef struct packed {
        logic [15:0]        tag;
        logic signed [15:0] score;
        logic signed [15:0] seval;
        logic [15:0]        move;
        logic [7:0]         depth;
        logic [4:0]         gen;
        logic [1:0]         bound;
        logic               pv;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_LOOK
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;   // write a zero row, advance clear counter
        logic lo_en;    // latch request and low partial product
        logic rd_en;    // finish bucket index, read the row
        logic wb_en;    // evaluate row: write back or load result
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_probe;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/bhtda_ctrl.sv =====
// Controller state machine: clearing pass, accept, hash/read, lookup/write-back.
// Depends on bhtda_pkg.
module bhtda_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bhtda_pkg::dp_status_t  status,
    output bhtda_pkg::ctrl_cmd_t   cmd
);
    import bhtda_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_HASH;
            ST_HASH:  state_next = ST_LOOK;
            ST_LOOK:  if (!(status.is_probe && status.out_busy)) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_en = 1'b1;
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.lo_en = in_valid;
            end
            ST_HASH:  cmd.rd_en = 1'b1;
            ST_LOOK:  cmd.wb_en = !(status.is_probe && status.out_busy);
            default:  cmd = '0;
        endcase
    end

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_en, cmd.lo_en, cmd.rd_en, cmd.wb_en}))
        else $error("more than one datapath command");

    // An accepted request always goes on to the row read
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.rd_en)
        else $error("accepted request not followed by read");

    // A probe with a pending result never overwrites it
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wb_en && status.is_probe) |-> !status.out_busy)
        else $error("probe result overwrote a pending result");

endmodule

// ===== rtl/bhtda_dp.sv =====
// Datapath: configuration registers, bucket hashing, row memory, replacement
// and mate-score adjustment, output register. Depends on bhtda_pkg.
module bhtda_dp #(
    parameter int BUCKETS            = 65536,
    parameter int ENTRIES_PER_BUCKET = 3,
    parameter int GEN_CYCLE          = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bhtda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bhtda_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  bhtda_pkg::req_t                   in_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bhtda_pkg::rsp_t                   out_rsp,
    input  bhtda_pkg::ctrl_cmd_t              cmd,
    output bhtda_pkg::dp_status_t             status
);
    import bhtda_pkg::*;

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW    = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
    localparam int ROW_W = ENTRIES_PER_BUCKET * ENTRY_W;

    // Configuration registers
    logic [16:0] bucket_count_reg;
    logic [4:0]  cur_gen_reg;
    logic [14:0] mate_thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
            cur_gen_reg      <= CUR_GEN_RST;
            mate_thresh_reg  <= MATE_THRESH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BUCKET_COUNT: bucket_count_reg <= cfg_data;
                CFG_CUR_GEN:      cur_gen_reg      <= cfg_data[4:0];
                CFG_MATE_THRESH:  mate_thresh_reg  <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    // Effective bucket count, clamped to 1..BUCKETS
    logic [16:0] n_eff;
    always_comb
    begin
        if (bucket_count_reg == 17'd0)
            n_eff = 17'd1;
        else if (32'(bucket_count_reg) > 32'(BUCKETS))
            n_eff = 17'(BUCKETS);
        else
            n_eff = bucket_count_reg;
    end

    // Request and low partial product, latched at accept
    req_t        req_reg;
    logic [16:0] lo_hi_reg;
    logic [48:0] lo_prod;
    assign lo_prod = in_req.key[31:0] * n_eff;

    always_ff @(posedge clk)
    begin
        if (cmd.lo_en)
        begin
            req_reg   <= in_req;
            lo_hi_reg <= lo_prod[48:32];
        end
    end

    // High partial product gives the bucket index
    logic [48:0] hi_prod;
    logic [63:0] hi_sum;
    logic [BW-1:0] bucket;
    assign hi_prod = req_reg.key[63:32] * n_eff;
    assign hi_sum  = 64'(hi_prod) + 64'(lo_hi_reg);
    assign bucket  = hi_sum[32 +: BW];

    logic [BW-1:0] bucket_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            bucket_reg <= bucket;
    end

    // Clear counter for the pass after reset
    logic [BW-1:0] clr_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_en)
            clr_cnt_reg <= clr_cnt_reg + BW'(1);
    end

    // Row memory: one bucket per row
    logic [ROW_W-1:0] mem [BUCKETS];
    logic [ROW_W-1:0] rdata_reg;
    logic [ROW_W-1:0] row_new;
    logic             wr_en;
    logic [BW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;

    assign wr_en   = cmd.clr_en || (cmd.wb_en && req_reg.cmd == CMD_STORE);
    assign wr_addr = cmd.clr_en ? clr_cnt_reg : bucket_reg;
    assign wr_data = cmd.clr_en ? '0 : row_new;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= mem[bucket];
    end

    // Lookup: first tag match and lowest-quality victim
    entry_t                   ent [ENTRIES_PER_BUCKET];
    logic [15:0]              tag;
    logic                     any_match;
    logic [PW-1:0]            match_idx;
    logic [PW-1:0]            min_idx;
    logic signed [11:0]       min_q;
    logic signed [11:0]       q;
    logic signed [8:0]        gdist;

    assign tag = req_reg.key[15:0];

    always_comb
    begin
        any_match = 1'b0;
        match_idx = '0;
        min_idx   = '0;
        min_q     = '0;
        for (int i = 0; i < ENTRIES_PER_BUCKET; i++)
        begin
            ent[i] = entry_t'(rdata_reg[i*ENTRY_W +: ENTRY_W]);
            gdist  = $signed({4'b0, cur_gen_reg}) - $signed({4'b0, ent[i].gen});
            if (gdist < 0)
                gdist = gdist + 9'(GEN_CYCLE);
            q = $signed({4'b0, ent[i].depth}) - $signed({gdist[8], gdist, 2'b0} >>> 1);
            if (!any_match && ent[i].tag == tag)
            begin
                any_match = 1'b1;
                match_idx = PW'(i);
            end
            if (i == 0 || q < min_q)
            begin
                min_q   = q;
                min_idx = PW'(i);
            end
        end
    end

    // Mate detection and ply adjustment
    logic [16:0]        thr17;
    logic signed [17:0] ply18;
    assign thr17 = {2'b0, mate_thresh_reg};
    assign ply18 = $signed({10'b0, req_reg.ply});

    function automatic logic is_mate(input logic signed [15:0] s, input logic [16:0] thr);
        logic [16:0] mag;
        mag = s[15] ? 17'(-$signed({s[15], s})) : {1'b0, s};
        return mag >= thr;
    endfunction

    // Store: build the replaced entry
    entry_t             victim;
    entry_t             upd;
    logic [PW-1:0]      pick;
    logic               same;
    logic               overwrite;
    logic signed [17:0] pushed;
    logic signed [15:0] pushed_sat;
    logic signed [10:0] depth_floor;

    assign pick   = any_match ? match_idx : min_idx;
    assign victim = ent[pick];
    assign same   = victim.tag == tag;

    always_comb
    begin
        pushed = $signed({{2{req_reg.eval_score[15]}}, req_reg.eval_score});
        if (is_mate(req_reg.eval_score, thr17))
            pushed = req_reg.eval_score[15] ? pushed - ply18 : pushed + ply18;
        if (pushed > 18'sd32767)
            pushed_sat = 16'sh7FFF;
        else if (pushed < -18'sd32768)
            pushed_sat = 16'sh8000;
        else
            pushed_sat = pushed[15:0];

        depth_floor = $signed({3'b0, victim.depth}) - 11'sd2
                      - (req_reg.pv_flag ? 11'sd2 : 11'sd0);
        overwrite = (req_reg.bound_kind == BOUND_EXACT) || !same
                    || ($signed({3'b0, req_reg.search_depth}) >= depth_floor)
                    || (victim.gen != cur_gen_reg);

        upd = victim;
        if (req_reg.best_move != 16'd0 || !same)
            upd.move = req_reg.best_move;
        if (overwrite)
        begin
            upd.tag   = tag;
            upd.seval = req_reg.static_eval;
            upd.depth = req_reg.search_depth;
            upd.score = pushed_sat;
            upd.gen   = cur_gen_reg;
            upd.bound = req_reg.bound_kind;
            upd.pv    = req_reg.pv_flag;
        end

        row_new = rdata_reg;
        for (int i = 0; i < ENTRIES_PER_BUCKET; i++)
        begin
            if (pick == PW'(i))
                row_new[i*ENTRY_W +: ENTRY_W] = upd;
        end
    end

    // Probe: result from first match, mate score pulled toward zero by the ply
    entry_t             hit_ent;
    logic signed [17:0] pulled;
    rsp_t               rsp_next;

    assign hit_ent = ent[match_idx];

    always_comb
    begin
        pulled = $signed({{2{hit_ent.score[15]}}, hit_ent.score});
        if (is_mate(hit_ent.score, thr17))
            pulled = hit_ent.score[15] ? pulled + ply18 : pulled - ply18;
        rsp_next = '0;
        if (any_match)
        begin
            rsp_next.hit         = 1'b1;
            rsp_next.found_score = pulled[15:0];
            rsp_next.found_eval  = hit_ent.seval;
            rsp_next.found_move  = hit_ent.move;
            rsp_next.found_depth = hit_ent.depth;
            rsp_next.found_bound = hit_ent.bound;
            rsp_next.found_pv    = hit_ent.pv;
        end
    end

    // Output register
    logic out_valid_reg;
    rsp_t out_rsp_reg;
    logic load_rsp;
    assign load_rsp = cmd.wb_en && req_reg.cmd == CMD_PROBE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_rsp)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
            out_rsp_reg <= rsp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // Status to controller
    assign status.clr_last = clr_cnt_reg == BW'(BUCKETS - 1);
    assign status.is_probe = req_reg.cmd == CMD_PROBE;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

// ===== rtl/bucketed_hash_table_depth_age_replace_unit.sv =====
// Probe result is registered on the output after hash and lookup; a store has no result.
// A request is taken only once the last has passed accept, bucket hash plus row read,
// lookup plus write-back, with the single read and write of one bucket row in row memory.
// A probe waits in lookup while an earlier result is still held on the output.
// After reset a clearing pass zeroes one row per cycle, all BUCKETS rows, with
// in_ready low; configuration writes are taken throughout.
module bucketed_hash_table_depth_age_replace_unit #(
    parameter int BUCKETS            = 65536,
    parameter int ENTRIES_PER_BUCKET = 3,
    parameter int GEN_CYCLE          = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bhtda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bhtda_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bhtda_pkg::req_t                   in_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bhtda_pkg::rsp_t                   out_rsp
);
    import bhtda_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller
    bhtda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    bhtda_dp #(
        .BUCKETS            (BUCKETS),
        .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET),
        .GEN_CYCLE          (GEN_CYCLE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
